>>> rtl/bprr_pkg.sv
// Shared types, constants and the frame byte table of the button press/release reporter.
package bprr_pkg;

  localparam int unsigned FrameLen   = 7;
  localparam int unsigned ByteIdxW   = 3;
  localparam int unsigned FifoDepthD = 2;

  localparam logic [15:0] HoldResetMs = 16'd1000;
  localparam logic [15:0] DeadResetMs = 16'd500;
  localparam logic [7:0]  AddrReset   = 8'h00;

  localparam logic [7:0] SyncByte0 = 8'h36;
  localparam logic [7:0] SyncByte1 = 8'h16;
  localparam logic [7:0] CmdByte   = 8'hA1;
  localparam logic [7:0] TailByte0 = 8'h28;
  localparam logic [7:0] TailByte1 = 8'h98;

  localparam logic [ByteIdxW-1:0] LastIdx = ByteIdxW'(FrameLen - 1);

  typedef enum logic [1:0] {
    REG_HOLD = 2'd0,
    REG_DEAD = 2'd1,
    REG_ADDR = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_POLL = 1'b1
  } op_e;

  typedef enum logic {
    KEY_DOWN = 1'b0,
    KEY_UP   = 1'b1
  } key_e;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_PUSHED   = 3'd1,
    MODE_HOLDING  = 3'd2,
    MODE_EARLY_UP = 3'd3,
    MODE_WAIT_UP  = 3'd4,
    MODE_RELEASED = 3'd5,
    MODE_DEAD     = 3'd6
  } mode_e;

  // Report request handed from the front part to the frame queue.
  typedef struct packed {
    logic push;
    key_e key;
  } frame_req_t;

  function automatic logic [7:0] frame_byte_at(input logic [ByteIdxW-1:0] idx,
                                               input logic [7:0] addr,
                                               input key_e key);
    logic [7:0] b;
    b = TailByte1;
    unique case (idx)
      3'd0:    b = SyncByte0;
      3'd1:    b = SyncByte1;
      3'd2:    b = addr;
      3'd3:    b = CmdByte;
      3'd4:    b = {7'd0, key};
      3'd5:    b = TailByte0;
      default: b = TailByte1;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/button_press_release_reporter.sv
// Top level of the button press/release reporter: configuration registers and part wiring.
//
// Input side: an edge or poll word is written with push while full is low.
// An edge word carries the pin level (low is pressed); a poll word carries
// the current millisecond count. The front part updates the button mode in
// the cycle the word is taken, so words may arrive on back-to-back cycles.
// A poll that completes a press or a release queues one report.
// Output side: each report leaves as seven frame bytes through a queue-like
// port; a byte is shown while empty is low and taken with pop. The first
// byte of a report appears after the poll that caused it has been written
// into the report queue and then loaded into the back part.
// full rises when the report queue (FifoDepth entries) is filled, which
// happens when reports come faster than frames drain or when the receiver
// stalls; the front then waits, and while pop is low the back part holds
// the current byte steady.
// Configuration: index 0 hold interval, 1 dead time, 2 board address;
// other indexes are ignored. Writes are always taken (cfg_ready_o is high).
// Reset puts the button in idle with a zero timestamp, empties the queue and
// loads the default hold (1000 ms), dead time (500 ms) and address (0).
module button_press_release_reporter import bprr_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthD
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic        pin_level_i,
  input  logic [31:0] now_ms_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_byte_o,
  output logic        frame_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] hold_ms_q;
  logic [15:0] dead_ms_q;
  logic [7:0]  addr_q;
  logic        accept;
  frame_req_t  req;
  logic        q_pop;
  logic        q_empty;
  key_e        q_key;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // Configuration registers; unknown indexes fall through untouched.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ms_q <= HoldResetMs;
      dead_ms_q <= DeadResetMs;
      addr_q    <= AddrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_HOLD: hold_ms_q <= cfg_data_i;
        REG_DEAD: dead_ms_q <= cfg_data_i;
        REG_ADDR: addr_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  bprr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (op_e'(operation_i)),
    .level_i   (pin_level_i),
    .now_i     (now_ms_i),
    .hold_ms_i (hold_ms_q),
    .dead_ms_i (dead_ms_q),
    .req_o     (req)
  );

  bprr_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .pop_i   (q_pop),
    .full_o  (full),
    .empty_o (q_empty),
    .key_o   (q_key)
  );

  bprr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_key_i   (q_key),
    .q_pop_o   (q_pop),
    .addr_i    (addr_q),
    .pop_i     (pop),
    .empty_o   (empty),
    .byte_o    (frame_byte_o),
    .last_o    (frame_last_o)
  );

endmodule

>>> rtl/bprr_front.sv
// Front part: takes edge and poll words, runs the button mode machine, requests reports.
module bprr_front import bprr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  op_e         op_i,
  input  logic        level_i,
  input  logic [31:0] now_i,
  input  logic [15:0] hold_ms_i,
  input  logic [15:0] dead_ms_i,
  output frame_req_t  req_o
);

  mode_e       mode_q, mode_d;
  logic [31:0] ts_q, ts_d;
  logic [31:0] elapsed;
  logic        hold_done;
  logic        dead_done;

  // Wrapping subtraction gives the elapsed time modulo 2^32.
  assign elapsed   = now_i - ts_q;
  assign hold_done = elapsed >= {16'd0, hold_ms_i};
  assign dead_done = elapsed >= {16'd0, dead_ms_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      ts_q   <= '0;
    end else begin
      mode_q <= mode_d;
      ts_q   <= ts_d;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    ts_d     = ts_q;
    req_o    = '{push: 1'b0, key: KEY_DOWN};
    if (accept_i) begin
      if (op_i == OP_EDGE) begin
        if (!level_i) begin
          unique case (mode_q)
            MODE_IDLE:     mode_d = MODE_PUSHED;
            MODE_EARLY_UP: mode_d = MODE_HOLDING;
            MODE_PUSHED, MODE_HOLDING, MODE_WAIT_UP, MODE_RELEASED, MODE_DEAD: ;
            default:       mode_d = MODE_PUSHED;
          endcase
        end else begin
          if (mode_q == MODE_WAIT_UP) begin
            mode_d = MODE_RELEASED;
          end else if (mode_q == MODE_HOLDING) begin
            mode_d = MODE_EARLY_UP;
          end
        end
      end else begin
        unique case (mode_q)
          MODE_PUSHED: begin
            ts_d   = now_i;
            mode_d = MODE_HOLDING;
            req_o  = '{push: 1'b1, key: KEY_DOWN};
          end
          MODE_HOLDING: begin
            if (hold_done) mode_d = MODE_WAIT_UP;
          end
          MODE_EARLY_UP: begin
            if (hold_done) mode_d = MODE_RELEASED;
          end
          MODE_RELEASED: begin
            ts_d   = now_i;
            mode_d = MODE_DEAD;
            req_o  = '{push: 1'b1, key: KEY_UP};
          end
          MODE_DEAD: begin
            if (dead_done) mode_d = MODE_IDLE;
          end
          MODE_IDLE, MODE_WAIT_UP: ;
          default: mode_d = MODE_IDLE;
        endcase
      end
    end
  end

endmodule

>>> rtl/bprr_fifo.sv
// Short queue of pending report keys between the front and back parts.
module bprr_fifo import bprr_pkg::*; #(
  parameter int unsigned Depth = FifoDepthD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  frame_req_t req_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       empty_o,
  output key_e       key_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  key_e            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign key_o   = mem_q[rd_ptr_q];
  assign do_push = req_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= req_i.key;
  end

endmodule

>>> rtl/bprr_back.sv
// Back part: serializes one queued report into seven frame bytes.
module bprr_back import bprr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  key_e       q_key_i,
  output logic       q_pop_o,
  input  logic [7:0] addr_i,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic                busy_q, busy_d;
  key_e                key_q, key_d;
  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic                taken;
  logic                at_last;

  assign empty_o = !busy_q;
  assign at_last = idx_q == LastIdx;
  assign taken   = pop_i && busy_q;
  assign last_o  = at_last;
  assign byte_o  = frame_byte_at(idx_q, addr_i, key_q);
  // Load the next report when idle or as the final byte of a frame leaves.
  assign q_pop_o = !q_empty_i && (!busy_q || (taken && at_last));

  always_comb begin
    busy_d = busy_q;
    key_d  = key_q;
    idx_d  = idx_q;
    if (q_pop_o) begin
      busy_d = 1'b1;
      key_d  = q_key_i;
      idx_d  = '0;
    end else if (taken) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

>>> tb/button_press_release_reporter_test.sv
// Self-checking testbench for the button press/release reporter with a built-in predictor.
module button_press_release_reporter_test;
  import bprr_pkg::*;

  // Index 3 has no register behind it; writes to it must leave every setting alone.
  localparam logic [1:0] RegSpare = 2'd3;
  // Longest stretch of cycles without any accepted word before the run is called hung.
  // It covers the long receiver hold-off, the longest sender gap and the quiet spells
  // around configuration writes several times over.
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldOffCycles = 300;

  // One input word as the sender sees it: an edge event or a millisecond poll.
  typedef struct packed {
    op_e         op;
    logic        level;
    logic [31:0] now;
  } button_word_t;

  // One output word: a single frame byte and its end-of-frame flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        operation_i = 1'b0;
  logic        pin_level_i = 1'b1;
  logic [31:0] now_ms_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  frame_byte_o;
  logic        frame_last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  button_press_release_reporter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .pin_level_i (pin_level_i),
    .now_ms_i    (now_ms_i),
    .empty       (empty),
    .pop         (pop),
    .frame_byte_o(frame_byte_o),
    .frame_last_o(frame_last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: its own copy of the button tracker and of the registers.
  mode_e       btn_mode = MODE_IDLE;
  logic [31:0] press_stamp = '0;
  logic [15:0] hold_ms = HoldResetMs;
  logic [15:0] dead_ms = DeadResetMs;
  logic [7:0]  board_addr = AddrReset;

  // Words waiting to be offered, and frame bytes the block still owes us.
  button_word_t word_backlog[$];
  frame_word_t  owed_frame_bytes[$];
  button_word_t offered_word;

  int unsigned items_queued = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned fail_count = 0;
  logic [31:0] ms_clock = '0;

  // Queues the seven bytes of one report in the order they leave the block.
  task automatic owe_report(input key_e key);
    logic [7:0] bytes [0:6];
    frame_word_t w;
    bytes[0] = SyncByte0;
    bytes[1] = SyncByte1;
    bytes[2] = board_addr;
    bytes[3] = CmdByte;
    bytes[4] = {7'd0, key};
    bytes[5] = TailByte0;
    bytes[6] = TailByte1;
    for (int k = 0; k < 7; k++) begin
      w.data = bytes[k];
      w.last = (k == 6);
      owed_frame_bytes.push_back(w);
    end
  endtask

  // Advances the predicted button tracker by one accepted word.
  task automatic track_button(input button_word_t w);
    logic [31:0] span;
    if (w.op == OP_EDGE) begin
      // Edges only move the mode; anything that does not fit the mode is dropped.
      if (w.level == 1'b0) begin
        if (btn_mode == MODE_IDLE) btn_mode = MODE_PUSHED;
        else if (btn_mode == MODE_EARLY_UP) btn_mode = MODE_HOLDING;
      end else begin
        if (btn_mode == MODE_WAIT_UP) btn_mode = MODE_RELEASED;
        else if (btn_mode == MODE_HOLDING) btn_mode = MODE_EARLY_UP;
      end
    end else begin
      // Elapsed time wraps naturally in 32 bits.
      span = w.now - press_stamp;
      case (btn_mode)
        MODE_PUSHED: begin
          press_stamp = w.now;
          btn_mode = MODE_HOLDING;
          owe_report(KEY_DOWN);
        end
        MODE_HOLDING: begin
          if (span >= {16'd0, hold_ms}) btn_mode = MODE_WAIT_UP;
        end
        MODE_EARLY_UP: begin
          if (span >= {16'd0, hold_ms}) btn_mode = MODE_RELEASED;
        end
        MODE_RELEASED: begin
          press_stamp = w.now;
          btn_mode = MODE_DEAD;
          owe_report(KEY_UP);
        end
        MODE_DEAD: begin
          if (span >= {16'd0, dead_ms}) btn_mode = MODE_IDLE;
        end
        default: ;
      endcase
    end
  endtask

  // Sender: offers backlog words in bursts of random length separated by random gaps.
  // A word stays on the ports until the edge where push is high and full is low.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        track_button(offered_word);
        words_in++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (word_backlog.size() != 0) begin
          offered_word = word_backlog.pop_front();
          push <= 1'b1;
          operation_i <= offered_word.op;
          pin_level_i <= offered_word.level;
          now_ms_i <= offered_word.now;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // About a third of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every popped word against the oldest owed byte, and drives pop
  // from a randomly redrawn pattern. Once, early in the first random phase, it
  // holds off for a long stretch so the report queue fills and full stalls the
  // sender.
  int unsigned rx_tick = 0;
  int unsigned rx_mode = 0;
  int unsigned hold_left = 0;
  logic        held_off = 1'b0;

  always @(posedge clk_i) begin
    frame_word_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        words_out++;
        if (owed_frame_bytes.size() == 0) begin
          fail_count++;
          $display("%0t: word with nothing owed, expected none, actual %02h last %0b",
                   $time, frame_byte_o, frame_last_o);
        end else begin
          want = owed_frame_bytes.pop_front();
          if (frame_byte_o !== want.data) begin
            fail_count++;
            $display("%0t: frame byte mismatch, expected %02h actual %02h",
                     $time, want.data, frame_byte_o);
          end
          if (frame_last_o !== want.last) begin
            fail_count++;
            $display("%0t: frame last mismatch, expected %0b actual %0b",
                     $time, want.last, frame_last_o);
          end
        end
      end

      rx_tick++;
      if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (!held_off && words_out >= 60) begin
        hold_left = HoldOffCycles;
        held_off = 1'b1;
      end

      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (rx_mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= (rx_tick % 3 == 0);
          default: pop <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run if no word moves on any channel for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no word accepted for %0d cycles", $time, StallLimit);
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic queue_edge(input logic level);
    button_word_t w;
    w.op = OP_EDGE;
    w.level = level;
    w.now = $urandom();
    word_backlog.push_back(w);
    items_queued++;
  endtask

  task automatic queue_poll(input logic [31:0] now);
    button_word_t w;
    w.op = OP_POLL;
    w.level = 1'($urandom_range(0, 1));
    w.now = now;
    word_backlog.push_back(w);
    items_queued++;
  endtask

  // Fully random words that break up whatever sequence is in progress.
  task automatic queue_noise(input int unsigned count);
    button_word_t w;
    repeat (count) begin
      w.op = op_e'($urandom_range(0, 1));
      w.level = 1'($urandom_range(0, 1));
      w.now = $urandom();
      word_backlog.push_back(w);
      items_queued++;
    end
  endtask

  // One well-formed press and release with random timing: press, down report,
  // polls inside the hold, an early or a late release, the up report, then
  // polls through the dead time until the button is idle again.
  task automatic queue_session();
    logic [31:0] t0;
    logic [31:0] t1;
    queue_edge(1'b0);
    if ($urandom_range(0, 3) == 0) queue_edge(1'b0);
    t0 = ms_clock + $urandom_range(0, 20);
    queue_poll(t0);
    if (hold_ms != 0) begin
      repeat ($urandom_range(0, 2)) queue_poll(t0 + $urandom_range(0, hold_ms - 1));
      if ($urandom_range(0, 2) == 0) queue_poll(t0 + hold_ms - 1);
    end
    if ($urandom_range(0, 1)) begin
      // Released before the hold ran out, possibly with a bounce back down.
      queue_edge(1'b1);
      if ($urandom_range(0, 2) == 0) begin
        queue_edge(1'b0);
        queue_edge(1'b1);
      end
      t0 = t0 + hold_ms + $urandom_range(0, 3);
      queue_poll(t0);
    end else begin
      t0 = t0 + hold_ms + $urandom_range(0, 3);
      queue_poll(t0);
      queue_edge(1'b1);
    end
    t1 = t0 + $urandom_range(0, 5);
    queue_poll(t1);
    if (dead_ms != 0 && $urandom_range(0, 1)) queue_poll(t1 + $urandom_range(0, dead_ms - 1));
    t1 = t1 + dead_ms + $urandom_range(0, 2);
    queue_poll(t1);
    ms_clock = t1 + $urandom_range(0, 50);
  endtask

  // Queues roughly count words, mostly whole sessions with some noise in between.
  task automatic random_phase(input int unsigned count);
    int unsigned goal;
    goal = items_queued + count;
    ms_clock = $urandom();
    while (items_queued < goal) begin
      if ($urandom_range(0, 4) == 0) queue_noise($urandom_range(1, 4));
      else queue_session();
    end
  endtask

  // Waits until every queued word is in and every owed byte is out, then lets the
  // block settle before anything else happens.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (words_in != items_queued || owed_frame_bytes.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes one register and mirrors the write into the predictor at the handshake.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      REG_HOLD: hold_ms = data;
      REG_DEAD: dead_ms = data;
      REG_ADDR: board_addr = data[7:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk at the reset settings (hold 1000, dead 500, address 0).
    queue_poll(32'h0000_0000);      // poll while idle gives nothing
    queue_edge(1'b1);               // release while idle is dropped
    queue_edge(1'b0);               // press
    queue_edge(1'b0);               // second press while pushed is dropped
    queue_poll(32'hFFFF_FF00);      // down report, timestamp near the top
    queue_poll(32'h0000_02E7);      // one short of the hold across the wrap
    queue_edge(1'b1);               // early release
    queue_edge(1'b0);               // pressed again before the hold ran out
    queue_edge(1'b1);               // and released again
    queue_poll(32'h0000_02E8);      // exactly the hold: release is due
    queue_edge(1'b0);               // press while the release is pending is dropped
    queue_poll(32'hFFFF_FFFF);      // up report, dead time starts
    queue_edge(1'b0);               // press during dead time is dropped
    queue_poll(32'h0000_01F2);      // one short of the dead time
    queue_poll(32'h0000_01F3);      // dead time over
    queue_edge(1'b0);
    queue_poll(32'd5000);           // down report
    queue_poll(32'd6000);           // held long enough, now waiting for release
    queue_edge(1'b0);               // press while waiting is dropped
    queue_edge(1'b1);               // release after the hold
    queue_edge(1'b1);               // repeated release is dropped
    queue_poll(32'd6001);           // up report
    queue_poll(32'd6501);           // dead time over
    wait_quiet();

    // Zero hold and dead time, top address, and a write to the unused index.
    write_reg(REG_HOLD, 16'h0000);
    write_reg(REG_DEAD, 16'h0000);
    write_reg(REG_ADDR, 16'h00FF);
    write_reg(RegSpare, 16'($urandom()));
    random_phase(90);
    wait_quiet();

    // Longest hold and dead time; only the low byte of the address data counts.
    write_reg(REG_HOLD, 16'hFFFF);
    write_reg(REG_DEAD, 16'hFFFF);
    write_reg(REG_ADDR, 16'hFF00);
    random_phase(80);
    wait_quiet();

    write_reg(REG_HOLD, 16'($urandom_range(1, 40)));
    write_reg(REG_DEAD, 16'($urandom_range(0, 40)));
    write_reg(REG_ADDR, 16'($urandom()));
    write_reg(RegSpare, 16'($urandom()));
    random_phase(90);
    wait_quiet();

    write_reg(REG_HOLD, 16'($urandom_range(0, 3)));
    write_reg(REG_DEAD, 16'($urandom()));
    write_reg(REG_ADDR, 16'($urandom()));
    random_phase(90);
    wait_quiet();
    repeat (20) @(posedge clk_i);

    if (owed_frame_bytes.size() != 0) begin
      fail_count++;
      $display("%0t: %0d frame bytes never arrived", $time, owed_frame_bytes.size());
    end
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
